// ===== rtl/wbr_pkg.sv =====
package wbr_pkg;

  // Fixed field widths of the request and result items.
  localparam int MAX_LOG2_LENGTH_DEF = 10;
  localparam int IDX_W               = 10;
  localparam int RANK_W              = 10;
  localparam int LOG2_W              = 4;
  localparam int CFG_W               = 11;
  localparam int REG_IDX_W           = 2;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_MODE        = 2'd0,
    REG_LOG2_LENGTH = 2'd1,
    REG_Z_INFO      = 2'd2,
    REG_X_CODE_SIZE = 2'd3
  } reg_idx_t;

  // Ordering modes.
  localparam logic MODE_WEIGHT = 1'b0;
  localparam logic MODE_LAST   = 1'b1;

  // Binomial coefficient C(a,b) for 0 <= a <= 16, built from a Pascal row.
  // Only evaluated at elaboration to fill constant tables.
  function automatic int binom(input int a, input int b);
    int row [0:16];
    int r;
    int k;
    for (k = 0; k <= 16; k++) row[k] = 0;
    row[0] = 1;
    for (r = 1; r <= a; r++) begin
      for (k = r; k >= 1; k--) row[k] = row[k] + row[k-1];
    end
    if (b > a || b < 0) return 0;
    return row[b];
  endfunction

  // Number of n-bit words whose weight is at least w.
  function automatic int tail_sum(input int n, input int w);
    int s;
    int j;
    s = 0;
    for (j = 0; j <= 16; j++) begin
      if (j >= w && j <= n) s = s + binom(n, j);
    end
    return s;
  endfunction

endpackage

// ===== rtl/wbr_cell.sv =====
module wbr_cell #(
  parameter int POS   = 0,
  parameter int CNT_W = 4,
  parameter int SUM_W = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      valid_in,
  output logic                      ready_out,
  input  logic [wbr_pkg::IDX_W-1:0] idx_in,
  input  logic [CNT_W-1:0]          cnt_in,
  input  logic [SUM_W-1:0]          below_in,
  output logic                      valid,
  input  logic                      ready_in,
  output logic [wbr_pkg::IDX_W-1:0] idx,
  output logic [CNT_W-1:0]          cnt,
  output logic [SUM_W-1:0]          below
);
  import wbr_pkg::*;

  localparam int TAB_N = 1 << CNT_W;

  // C(POS, k) for every count this cell can see.
  logic [SUM_W-1:0] ctab [0:TAB_N-1];
  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    assign ctab[k] = SUM_W'(binom(POS, k));
  end

  logic             bit_set;
  logic [CNT_W-1:0] cnt_next;
  logic [SUM_W-1:0] below_next;

  // A set bit at this position is the j-th one seen; it adds C(POS, j)
  // to the count of same-weight words below the index.
  always_comb begin
    bit_set    = idx_in[POS];
    cnt_next   = cnt_in + CNT_W'(bit_set);
    below_next = bit_set ? below_in + ctab[cnt_next] : below_in;
  end

  assign ready_out = !valid || ready_in;

  // Stage valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready_out) begin
      valid <= valid_in;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      idx   <= idx_in;
      cnt   <= cnt_next;
      below <= below_next;
    end
  end

endmodule

// ===== rtl/wbr_rank.sv =====
module wbr_rank #(
  parameter int MAX_LOG2_LENGTH = 10,
  parameter int CNT_W           = 4,
  parameter int SUM_W           = 10
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid_in,
  output logic                       ready_out,
  input  logic [wbr_pkg::IDX_W-1:0]  idx_in,
  input  logic [CNT_W-1:0]           weight_in,
  input  logic [SUM_W-1:0]           below_in,
  input  logic                       mode,
  input  logic [CNT_W-1:0]           n_eff,
  input  logic [wbr_pkg::CFG_W-1:0]  kz,
  input  logic [wbr_pkg::CFG_W-1:0]  kx,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [wbr_pkg::RANK_W-1:0] reliability_rank,
  output logic                       z_frozen,
  output logic                       x_stab_info,
  output logic                       index_out_of_range
);
  import wbr_pkg::*;

  localparam int TAB_N = 1 << CNT_W;
  localparam int LW    = (MAX_LOG2_LENGTH >= 10) ? MAX_LOG2_LENGTH + 2 : 12;

  // Count of words at least as heavy as w, for every length n up to the cap.
  // Lengths past the cap are never selected and read as zero.
  logic [MAX_LOG2_LENGTH:0] ttab [0:TAB_N-1][0:TAB_N-1];
  for (genvar nn = 0; nn < TAB_N; nn++) begin : g_n
    for (genvar ww = 0; ww < TAB_N; ww++) begin : g_w
      if (nn <= MAX_LOG2_LENGTH) begin : g_used
        assign ttab[nn][ww] = (MAX_LOG2_LENGTH + 1)'(tail_sum(nn, ww));
      end else begin : g_unused
        assign ttab[nn][ww] = '0;
      end
    end
  end

  logic [LW-1:0] len;
  logic [LW-1:0] idx_w;
  logic [LW-1:0] wrank;
  logic [LW-1:0] lrank;
  logic [LW-1:0] rank;
  logic          oor;
  logic [RANK_W-1:0] rank_next;
  logic          zf_next;
  logic          xs_next;

  // Weight mode: heavier words plus same-weight words above this index.
  // Last-positions mode: N-1-index.
  always_comb begin
    len   = LW'(1) << n_eff;
    idx_w = LW'(idx_in);
    oor   = idx_w >= len;
    wrank = LW'(ttab[n_eff][weight_in]) - LW'(1) - LW'(below_in);
    lrank = len - LW'(1) - idx_w;
    rank  = (mode == MODE_LAST) ? lrank : wrank;
    if (oor) begin
      rank_next = '0;
      zf_next   = 1'b0;
      xs_next   = 1'b0;
    end else begin
      rank_next = rank[RANK_W-1:0];
      zf_next   = rank >= LW'(kz);
      xs_next   = (rank + LW'(kx)) < len;
    end
  end

  assign ready_out = !out_valid || !out_stall;

  // Output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready_out) begin
      out_valid <= valid_in;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (ready_out && valid_in) begin
      reliability_rank   <= rank_next;
      z_frozen           <= zf_next;
      x_stab_info        <= xs_next;
      index_out_of_range <= oor;
    end
  end

endmodule

// ===== rtl/weight_order_frozen_bit_ranker_unit.sv =====
// Channel    Signals                                 Direction
// request    in_valid, in_stall, channel_index       in
// result     out_valid, out_stall, reliability_rank,
//            z_frozen, x_stab_info,
//            index_out_of_range                      out
// config     cfg_write, cfg_index, cfg_data          in
//
// One request is taken per cycle while the first cell has room; each passes a
// row of one cell per index bit (min(MAX_LOG2_LENGTH, 10) cells) and then the
// rank stage. The first cell loads at the accepting edge, then each later cell
// and the rank stage in turn. Reset is synchronous; it empties every stage and
// loads the register defaults. A stalled result holds; each stage keeps taking
// data while the stage after it has room, so empty stages close up behind it.
module weight_order_frozen_bit_ranker_unit #(
  parameter int MAX_LOG2_LENGTH = wbr_pkg::MAX_LOG2_LENGTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wbr_pkg::IDX_W-1:0]     channel_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wbr_pkg::RANK_W-1:0]    reliability_rank,
  output logic                          z_frozen,
  output logic                          x_stab_info,
  output logic                          index_out_of_range,
  input  logic                          cfg_write,
  input  logic [wbr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [wbr_pkg::CFG_W-1:0]     cfg_data
);
  import wbr_pkg::*;

  localparam int CNT_W = $clog2(MAX_LOG2_LENGTH + 1);
  localparam int SUM_W = MAX_LOG2_LENGTH;
  localparam int CELLS = (MAX_LOG2_LENGTH < IDX_W) ? MAX_LOG2_LENGTH : IDX_W;

  logic              mode;
  logic [LOG2_W-1:0] log2_length;
  logic [CFG_W-1:0]  z_info_count;
  logic [CFG_W-1:0]  x_code_size;
  logic [CNT_W-1:0]  n_eff;
  reg_idx_t          cfg_sel;

  assign cfg_sel = reg_idx_t'(cfg_index);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_WEIGHT;
      log2_length  <= LOG2_W'(10);
      z_info_count <= '0;
      x_code_size  <= CFG_W'(1024);
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_MODE:        mode         <= cfg_data[0];
        REG_LOG2_LENGTH: log2_length  <= cfg_data[LOG2_W-1:0];
        REG_Z_INFO:      z_info_count <= cfg_data;
        REG_X_CODE_SIZE: x_code_size  <= cfg_data;
        default:         mode         <= mode;
      endcase
    end
  end

  // Length clamped to 1..MAX_LOG2_LENGTH.
  always_comb begin
    if (log2_length == '0) begin
      n_eff = CNT_W'(1);
    end else if (int'(log2_length) > MAX_LOG2_LENGTH) begin
      n_eff = CNT_W'(MAX_LOG2_LENGTH);
    end else begin
      n_eff = CNT_W'(log2_length);
    end
  end

  // Links between the cells; link 0 is the request port.
  logic             valid_c [0:CELLS];
  logic             ready_c [0:CELLS];
  logic [IDX_W-1:0] idx_c   [0:CELLS];
  logic [CNT_W-1:0] cnt_c   [0:CELLS];
  logic [SUM_W-1:0] below_c [0:CELLS];

  assign valid_c[0] = in_valid;
  assign idx_c[0]   = channel_index;
  assign cnt_c[0]   = '0;
  assign below_c[0] = '0;
  assign in_stall   = !ready_c[0];

  // One cell per low index bit, min(MAX_LOG2_LENGTH, 10) in all.
  for (genvar p = 0; p < CELLS; p++) begin : g_cell
    wbr_cell #(
      .POS   (p),
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .valid_in  (valid_c[p]),
      .ready_out (ready_c[p]),
      .idx_in    (idx_c[p]),
      .cnt_in    (cnt_c[p]),
      .below_in  (below_c[p]),
      .valid     (valid_c[p+1]),
      .ready_in  (ready_c[p+1]),
      .idx       (idx_c[p+1]),
      .cnt       (cnt_c[p+1]),
      .below     (below_c[p+1])
    );
  end

  // Final rank, flags and output register.
  wbr_rank #(
    .MAX_LOG2_LENGTH (MAX_LOG2_LENGTH),
    .CNT_W           (CNT_W),
    .SUM_W           (SUM_W)
  ) u_rank (
    .clk                (clk),
    .rst                (rst),
    .valid_in           (valid_c[CELLS]),
    .ready_out          (ready_c[CELLS]),
    .idx_in             (idx_c[CELLS]),
    .weight_in          (cnt_c[CELLS]),
    .below_in           (below_c[CELLS]),
    .mode               (mode),
    .n_eff              (n_eff),
    .kz                 (z_info_count),
    .kx                 (x_code_size),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .reliability_rank   (reliability_rank),
    .z_frozen           (z_frozen),
    .x_stab_info        (x_stab_info),
    .index_out_of_range (index_out_of_range)
  );

endmodule
